@@ rtl/sop_pkg.sv @@
// Package for the two-list set operation engine.
// Holds field widths, command and operation codes and the controller state type.
// No dependencies.
package sop_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [OP_W-1:0] {
    OP_INTERSECT = 2'd0,
    OP_UNION     = 2'd1,
    OP_ONLY_A    = 2'd2,
    OP_ONLY_B    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FINISH
  } state_e;

endpackage

@@ rtl/sop_in_if.sv @@
// Input channel of the set operation engine: command and pushed value.
// Depends on sop_pkg for the field widths.
interface sop_in_if;
  logic                              valid;
  logic                              ready;
  logic [sop_pkg::CMD_W-1:0]         cmd;
  logic signed [sop_pkg::VALUE_W-1:0] element_value;

  modport source (output valid, output cmd, output element_value, input ready);
  modport sink   (input valid, input cmd, input element_value, output ready);
endinterface

@@ rtl/sop_out_if.sv @@
// Result channel of the set operation engine: one result value and its flags.
// Depends on sop_pkg for the field widths.
interface sop_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sop_pkg::VALUE_W-1:0] result_value;
  logic                               last_of_run;
  logic                               empty_result;
  logic                               overflow_seen;

  modport source (output valid, output result_value, output last_of_run,
                  output empty_result, output overflow_seen, input ready);
  modport sink   (input valid, input result_value, input last_of_run,
                  input empty_result, input overflow_seen, output ready);
endinterface

@@ rtl/sop_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sop_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/two_list_set_operation_engine_top.sv @@
// Two-list set operation engine: top level with list memories and run controller.
// Depends on sop_pkg, sop_in_if, sop_out_if and sop_ram.

// Push and clear items complete when accepted. A run item walks the source list;
// for element i it reads the element (S_WALK, S_LOAD), then, when max(i, other
// count) is nonzero, scans both list memories side by side over that many
// addresses (S_SCAN, then S_DRAIN for the registered read), then decides in
// S_DECIDE, which waits while the output register is full. This repeats per list
// walked, and S_FINISH closes the run. Each list memory has a single read port.
// Results leave through an output register; the block takes no new item while
// a run is in progress. No clearing pass is needed after reset.
module two_list_set_operation_engine_top #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  sop_in_if.sink      in_i,
  sop_out_if.source   out_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned VW = sop_pkg::VALUE_W;

  sop_pkg::state_e state_q, state_d;
  sop_pkg::op_e    op_q;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic          ovf_q, ovf_d;
  logic          walk2_q, walk2_d;
  logic          src_b_q, src_b_d;
  logic          use_oth_q, use_oth_d;
  logic          want_q, want_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lim_q, lim_d, pj_q, pj_d;
  logic [VW-1:0] v_q, v_d, keep_q, keep_d;
  logic          dup_q, dup_d, hit_q, hit_d, pv_q, pv_d, have_q, have_d;
  logic          ov_q, ov_d, ol_q, ol_d, oe_q, oe_d, oo_q, oo_d;
  logic [VW-1:0] ovl_q, ovl_d;

  logic          in_acc, out_busy, push_a, push_b, emit, dup_n, hit_n;
  logic [CW-1:0] n_src, n_oth;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rd_a, rd_b, src_rd, oth_rd;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_busy = ov_q && !out_o.ready;
  assign in_i.ready = (state_q == sop_pkg::S_IDLE);

  assign push_a = in_acc && (in_i.cmd == sop_pkg::CMD_PUSH_A) &&
                  (cnt_a_q != CW'(LIST_DEPTH));
  assign push_b = in_acc && (in_i.cmd == sop_pkg::CMD_PUSH_B) &&
                  (cnt_b_q != CW'(LIST_DEPTH));

  // Source and comparison list views for the current walk.
  assign n_src  = src_b_q ? cnt_b_q : cnt_a_q;
  assign n_oth  = use_oth_q ? (src_b_q ? cnt_a_q : cnt_b_q) : '0;
  assign src_rd = src_b_q ? rd_b : rd_a;
  assign oth_rd = src_b_q ? rd_a : rd_b;
  assign raddr  = (state_q == sop_pkg::S_SCAN) ? j_q[AW-1:0] : i_q[AW-1:0];

  // Compare results of the read that returns this cycle.
  assign dup_n = dup_q | (pv_q && (pj_q < i_q) && (src_rd == v_q));
  assign hit_n = hit_q | (pv_q && (pj_q < n_oth) && (oth_rd == v_q));
  assign emit  = !dup_q && (!use_oth_q || (hit_q == want_q));

  sop_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (push_a),
    .waddr_i (cnt_a_q[AW-1:0]),
    .wdata_i (in_i.element_value),
    .raddr_i (raddr),
    .rdata_o (rd_a)
  );

  sop_ram #(.WIDTH(VW), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (push_b),
    .waddr_i (cnt_b_q[AW-1:0]),
    .wdata_i (in_i.element_value),
    .raddr_i (raddr),
    .rdata_o (rd_b)
  );

  // Next state of the run controller.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sop_pkg::S_IDLE: begin
        if (in_acc && (in_i.cmd == sop_pkg::CMD_RUN)) state_d = sop_pkg::S_WALK;
      end
      sop_pkg::S_WALK: begin
        if (i_q != n_src) begin
          state_d = sop_pkg::S_LOAD;
        end else if (!(op_q == sop_pkg::OP_UNION && !walk2_q)) begin
          state_d = sop_pkg::S_FINISH;
        end
      end
      sop_pkg::S_LOAD: begin
        state_d = ((i_q > n_oth) ? i_q : n_oth) == '0 ? sop_pkg::S_DECIDE
                                                     : sop_pkg::S_SCAN;
      end
      sop_pkg::S_SCAN: begin
        if (j_q + CW'(1) == lim_q) state_d = sop_pkg::S_DRAIN;
      end
      sop_pkg::S_DRAIN: state_d = sop_pkg::S_DECIDE;
      sop_pkg::S_DECIDE: begin
        if (!(emit && have_q && out_busy)) state_d = sop_pkg::S_WALK;
      end
      sop_pkg::S_FINISH: begin
        if (!out_busy) state_d = sop_pkg::S_IDLE;
      end
      default: state_d = sop_pkg::S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    cnt_a_d = cnt_a_q;  cnt_b_d = cnt_b_q;  ovf_d = ovf_q;
    walk2_d = walk2_q;  src_b_d = src_b_q;  use_oth_d = use_oth_q;
    want_d = want_q;    i_d = i_q;  j_d = j_q;  lim_d = lim_q;  pj_d = pj_q;
    v_d = v_q;  keep_d = keep_q;  dup_d = dup_q;  hit_d = hit_q;
    pv_d = pv_q;  have_d = have_q;
    ov_d = ov_q && !out_o.ready;
    ol_d = ol_q;  oe_d = oe_q;  oo_d = oo_q;  ovl_d = ovl_q;
    unique case (state_q)
      sop_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (sop_pkg::cmd_e'(in_i.cmd))
            sop_pkg::CMD_PUSH_A: begin
              if (push_a) cnt_a_d = cnt_a_q + CW'(1);
              else ovf_d = 1'b1;
            end
            sop_pkg::CMD_PUSH_B: begin
              if (push_b) cnt_b_d = cnt_b_q + CW'(1);
              else ovf_d = 1'b1;
            end
            sop_pkg::CMD_CLEAR: begin
              cnt_a_d = '0;
              cnt_b_d = '0;
            end
            sop_pkg::CMD_RUN: begin
              i_d = '0;
              walk2_d = 1'b0;
              have_d = 1'b0;
              src_b_d = (op_q == sop_pkg::OP_ONLY_B);
              use_oth_d = (op_q != sop_pkg::OP_UNION);
              want_d = (op_q == sop_pkg::OP_INTERSECT);
            end
            default: ;
          endcase
        end
      end
      sop_pkg::S_WALK: begin
        // Union continues with list B, excluding values held in list A.
        if (i_q == n_src && op_q == sop_pkg::OP_UNION && !walk2_q) begin
          walk2_d = 1'b1;
          src_b_d = 1'b1;
          use_oth_d = 1'b1;
          want_d = 1'b0;
          i_d = '0;
        end
      end
      sop_pkg::S_LOAD: begin
        v_d = src_rd;
        lim_d = (i_q > n_oth) ? i_q : n_oth;
        j_d = '0;
        dup_d = 1'b0;
        hit_d = 1'b0;
        pv_d = 1'b0;
      end
      sop_pkg::S_SCAN: begin
        dup_d = dup_n;
        hit_d = hit_n;
        pv_d = 1'b1;
        pj_d = j_q;
        j_d = j_q + CW'(1);
      end
      sop_pkg::S_DRAIN: begin
        dup_d = dup_n;
        hit_d = hit_n;
        pv_d = 1'b0;
      end
      sop_pkg::S_DECIDE: begin
        if (!(emit && have_q && out_busy)) begin
          i_d = i_q + CW'(1);
          if (emit) begin
            if (have_q) begin
              ov_d = 1'b1;  ovl_d = keep_q;  ol_d = 1'b0;
              oe_d = 1'b0;  oo_d = ovf_q;
            end
            keep_d = v_q;
            have_d = 1'b1;
          end
        end
      end
      sop_pkg::S_FINISH: begin
        if (!out_busy) begin
          ov_d = 1'b1;
          ovl_d = have_q ? keep_q : '0;
          ol_d = 1'b1;
          oe_d = !have_q;
          oo_d = ovf_q;
          have_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sop_pkg::S_IDLE;
      op_q    <= sop_pkg::OP_INTERSECT;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
      have_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) op_q <= sop_pkg::op_e'(cfg_wdata_i);
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      have_q  <= have_d;
      pv_q    <= pv_d;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    walk2_q <= walk2_d;  src_b_q <= src_b_d;  use_oth_q <= use_oth_d;
    want_q <= want_d;    i_q <= i_d;  j_q <= j_d;  lim_q <= lim_d;  pj_q <= pj_d;
    v_q <= v_d;  keep_q <= keep_d;  dup_q <= dup_d;  hit_q <= hit_d;
    ol_q <= ol_d;  oe_q <= oe_d;  oo_q <= oo_d;  ovl_q <= ovl_d;
  end

  assign out_o.valid         = ov_q;
  assign out_o.result_value  = ovl_q;
  assign out_o.last_of_run   = ol_q;
  assign out_o.empty_result  = oe_q;
  assign out_o.overflow_seen = oo_q;

  // A pending result never outlives its run.
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sop_pkg::S_IDLE) |-> !have_q) else $error("pending item at idle");

  // List counts stay within the list depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
    else $error("list count out of range");

  // An empty-result item is the last one of its run and carries zero.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oe_q) |-> (ol_q && ovl_q == '0)) else $error("bad empty item");

  // The walk index never passes the source list length.
  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sop_pkg::S_LOAD) |-> (i_q < n_src)) else $error("walk overrun");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the two-list set operation engine.
// Drives pushes, runs and clears with random idling and checks every result item
// against an in-bench set model. Depends on sop_pkg, sop_in_if, sop_out_if and the top level.

// Result item as predicted and as observed.
typedef struct packed {
  logic signed [31:0] value;
  logic               last;
  logic               empty;
  logic               ovf;
} set_item_t;

// Scoreboard: keeps the list model and the queue of expected result items.
class set_scoreboard;
  logic [31:0]    list_a[$];
  logic [31:0]    list_b[$];
  bit             ovf_flag;
  sop_pkg::op_e   op;
  set_item_t      pending[$];
  int             errors;
  int unsigned    depth;

  function new(int unsigned d);
    depth = d;
    op = sop_pkg::OP_INTERSECT;
  endfunction

  static function bit holds(logic [31:0] q[$], int n, logic [31:0] v);
    for (int i = 0; i < n && i < q.size(); i++)
      if (q[i] == v) return 1;
    return 0;
  endfunction

  // Append the first occurrences of src whose membership in other matches, skipping values held in excl.
  function void walk(logic [31:0] src[$], logic [31:0] other[$], bit use_other,
                     bit want, logic [31:0] excl[$], bit use_excl);
    set_item_t it;
    for (int i = 0; i < src.size(); i++) begin
      if (holds(src, i, src[i])) continue;
      if (use_other && holds(other, other.size(), src[i]) != want) continue;
      if (use_excl && holds(excl, excl.size(), src[i])) continue;
      it = '{value: src[i], last: 1'b0, empty: 1'b0, ovf: ovf_flag};
      pending.push_back(it);
    end
  endfunction

  // Note an accepted input item and predict what it causes.
  function void note_command(sop_pkg::cmd_e c, logic [31:0] v);
    int start;
    set_item_t it;
    case (c)
      sop_pkg::CMD_PUSH_A: begin
        if (list_a.size() < depth) list_a.push_back(v); else ovf_flag = 1;
      end
      sop_pkg::CMD_PUSH_B: begin
        if (list_b.size() < depth) list_b.push_back(v); else ovf_flag = 1;
      end
      sop_pkg::CMD_CLEAR: begin
        list_a.delete();
        list_b.delete();
      end
      default: begin
        start = pending.size();
        case (op)
          sop_pkg::OP_INTERSECT: walk(list_a, list_b, 1, 1, list_a, 0);
          sop_pkg::OP_UNION: begin
            walk(list_a, list_b, 0, 0, list_a, 0);
            walk(list_b, list_a, 0, 0, list_a, 1);
          end
          sop_pkg::OP_ONLY_A: walk(list_a, list_b, 1, 0, list_a, 0);
          default: walk(list_b, list_a, 1, 0, list_a, 0);
        endcase
        if (pending.size() == start) begin
          it = '{value: '0, last: 1'b1, empty: 1'b1, ovf: ovf_flag};
          pending.push_back(it);
        end else begin
          pending[pending.size()-1].last = 1'b1;
        end
      end
    endcase
  endfunction

  // Compare one accepted result item with the oldest expectation.
  function void check_result(set_item_t got);
    set_item_t exp;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result item %h", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.value !== exp.value) begin
      $display("%0t: result_value expected %0d actual %0d", $time, exp.value, got.value);
      errors++;
    end
    if (got.last !== exp.last) begin
      $display("%0t: last_of_run expected %b actual %b", $time, exp.last, got.last);
      errors++;
    end
    if (got.empty !== exp.empty) begin
      $display("%0t: empty_result expected %b actual %b", $time, exp.empty, got.empty);
      errors++;
    end
    if (got.ovf !== exp.ovf) begin
      $display("%0t: overflow_seen expected %b actual %b", $time, exp.ovf, got.ovf);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int ITEMS = 380;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;

  sop_in_if  in_ch();
  sop_out_if out_ch();

  two_list_set_operation_engine_top #(.LIST_DEPTH(DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  set_scoreboard board = new(DEPTH);
  bit calm_phase;      // no idling on either side
  int hold_cycles;     // receiver hold-off request, counted by the receiver
  int unsigned cycle_count;
  int items_sent;
  logic [31:0] pool[8];

  always #5 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = sop_pkg::CMD_PUSH_A;
    in_ch.element_value = '0;
    out_ch.ready = 1'b0;
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready)
      board.check_result('{value: out_ch.result_value, last: out_ch.last_of_run,
                           empty: out_ch.empty_result, ovf: out_ch.overflow_seen});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm_phase || ($urandom_range(99) >= 7);
    end
  end

  // Offer one item and wait until it is accepted, with random idle gaps.
  // Valid stays high after acceptance; idle gaps and drain() lower it.
  task automatic send_item(sop_pkg::cmd_e c, logic [31:0] v);
    while (!calm_phase && $urandom_range(99) < 7) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.element_value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_command(c, v);
    items_sent++;
  endtask

  // Wait until every expected item has arrived and the block has settled.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_op(sop_pkg::op_e o);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= o;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.op = o;
  endtask

  // Values drawn from a small pool so that the lists overlap often.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(9) < 8) return pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // One random set: an optional clear, pushes to both lists, then a run.
  task automatic random_set(int max_len);
    int na, nb;
    na = $urandom_range(max_len);
    nb = $urandom_range(max_len);
    if ($urandom_range(3) != 0) send_item(sop_pkg::CMD_CLEAR, $urandom());
    for (int i = 0; i < na + nb; i++)
      send_item(($urandom_range(na + nb - 1) < na) ? sop_pkg::CMD_PUSH_A
                                                   : sop_pkg::CMD_PUSH_B, pick_value());
    send_item(sop_pkg::CMD_RUN, $urandom());
  endtask

  initial begin
    sop_pkg::op_e o;
    calm_phase = 0;
    hold_cycles = 0;
    cycle_count = 0;
    items_sent = 0;
    pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
             32'h1, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty run, extremes, duplicates, every operation.
    send_item(sop_pkg::CMD_RUN, 32'h0);
    send_item(sop_pkg::CMD_PUSH_A, 32'h8000_0000);
    send_item(sop_pkg::CMD_PUSH_A, 32'h7fff_ffff);
    send_item(sop_pkg::CMD_PUSH_A, 32'h8000_0000);
    send_item(sop_pkg::CMD_PUSH_A, 32'hffff_ffff);
    send_item(sop_pkg::CMD_PUSH_B, 32'h7fff_ffff);
    send_item(sop_pkg::CMD_PUSH_B, 32'h0);
    send_item(sop_pkg::CMD_PUSH_B, 32'h0);
    send_item(sop_pkg::CMD_RUN, 32'hffff_ffff);
    for (int k = 1; k < 4; k++) begin
      write_op(sop_pkg::op_e'(k));
      send_item(sop_pkg::CMD_RUN, 32'h0);
    end
    // Fill list B past full to set the sticky overflow flag, run, then clear and run.
    for (int i = 0; i < 31; i++) send_item(sop_pkg::CMD_PUSH_B, i);
    send_item(sop_pkg::CMD_RUN, 32'h0);
    send_item(sop_pkg::CMD_CLEAR, 32'h0);
    send_item(sop_pkg::CMD_RUN, 32'h0);

    // Random sets under several settings; the middle stretch has no idling.
    for (int s = 0; items_sent < ITEMS; s++) begin
      if (s % 6 == 0) begin
        o = sop_pkg::op_e'($urandom_range(3));
        write_op(o);
      end
      calm_phase = (s >= 10 && s < 16);
      if (s == 4) begin
        // Long receiver hold-off while the sender keeps offering runs.
        hold_cycles = 600;
        send_item(sop_pkg::CMD_RUN, 32'h0);
        send_item(sop_pkg::CMD_RUN, 32'h0);
        send_item(sop_pkg::CMD_RUN, 32'h0);
      end
      if (s == 8) drain();   // sender pauses until all results are back
      if (s == 20) begin
        // Full list A and overflow on list A.
        send_item(sop_pkg::CMD_CLEAR, 32'h0);
        for (int i = 0; i < 34; i++) send_item(sop_pkg::CMD_PUSH_A, pick_value());
        send_item(sop_pkg::CMD_RUN, 32'h0);
      end
      random_set(s % 9 == 0 ? 20 : 6);
    end
    write_op(sop_pkg::OP_ONLY_B);
    write_op(sop_pkg::OP_INTERSECT);
    send_item(sop_pkg::CMD_RUN, 32'h0);
    drain();

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
